[rtl/core/pebb_pkg.sv]
// Shared types, constants and fixed-point helpers for the particle Euler step block.
package pebb_pkg;

  // Reset values of the configuration registers.
  localparam logic [30:0] HALF_EXTENT_RST = 31'd196608000;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd6553600;
  localparam logic [16:0] TIME_STEP_RST   = 17'd655;

  // Depth of the root and quotient pipelines, one result bit per stage.
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 32;

  typedef enum logic [1:0] {
    CFG_HALF_EXTENT = 2'd0,
    CFG_SPEED_LIMIT = 2'd1,
    CFG_TIME_STEP   = 2'd2
  } pebb_cfg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } pebb_in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_vx;
    logic signed [31:0] next_vy;
    logic               speed_capped;
  } pebb_out_t;

  // Particle state carried alongside the speed limiting pipelines.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               capped;
  } pebb_side_t;

  // Word carried through the root pipeline: state plus scaled numerators.
  typedef struct packed {
    pebb_side_t  side;
    logic [61:0] num_x;
    logic [61:0] num_y;
  } pebb_root_tag_t;

  // Saturate a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Scale a product by dt back to Q16.16, rounding half up.
  function automatic logic signed [33:0] rnd_dt(input logic signed [49:0] p);
    logic signed [49:0] t;
    t = p + 50'sd32768;
    return t[49:16];
  endfunction

endpackage

[rtl/core/particle_euler_step_box_bounce.sv]
// A particle passes the motion stages, stages five to seven, the square root, the divider and the output register.
// Throughput: one particle per cycle; busy_o is never raised and start_i may be high every cycle.
// Depth is set by the 32-stage square root and the 32-stage divider, one bit per stage.
// Results cannot be held off, so each result word is shown for exactly one cycle.
// Reset is asynchronous and active low; it empties the pipeline and restores the configuration registers.
module particle_euler_step_box_bounce import pebb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  pebb_in_t    item_i,
  output logic        result_valid_o,
  output pebb_out_t   result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  localparam int unsigned LATENCY = 7 + SQRT_STAGES + DIV_STAGES + 1;

  // Configuration registers.
  logic [30:0] half_extent_q, speed_limit_q;
  logic [16:0] time_step_q;
  logic [61:0] lim_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_extent_q <= HALF_EXTENT_RST;
      speed_limit_q <= SPEED_LIMIT_RST;
      time_step_q   <= TIME_STEP_RST;
    end else if (cfg_we_i) begin
      case (pebb_cfg_e'(cfg_idx_i))
        CFG_HALF_EXTENT: half_extent_q <= cfg_data_i;
        CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i;
        CFG_TIME_STEP:   time_step_q   <= cfg_data_i[16:0];
        default:         ;
      endcase
    end
  end

  // Squared limit, refreshed every cycle from the register.
  always_ff @(posedge clk_i) begin
    lim_sq_q <= speed_limit_q * speed_limit_q;
  end

  assign busy_o = 1'b0;

  // Motion stages.
  logic       mo_vld;
  pebb_side_t mo_side;

  pebb_motion u_motion (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i && !busy_o),
    .item_i        (item_i),
    .half_extent_i (half_extent_q),
    .time_step_i   (time_step_q),
    .valid_o       (mo_vld),
    .side_o        (mo_side)
  );

  // Stage five: velocity magnitudes.
  logic        s5_vld_q;
  pebb_side_t  s5_side_q;
  logic [31:0] s5_ux_q, s5_uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= mo_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_side_q <= mo_side;
    s5_ux_q   <= mo_side.vel_x[31] ? 32'(-mo_side.vel_x) : 32'(mo_side.vel_x);
    s5_uy_q   <= mo_side.vel_y[31] ? 32'(-mo_side.vel_y) : 32'(mo_side.vel_y);
  end

  // Stage six: squares and the limit-scaled numerators.
  logic        s6_vld_q;
  pebb_side_t  s6_side_q;
  logic [63:0] s6_sqx_q, s6_sqy_q;
  logic [61:0] s6_numx_q, s6_numy_q;
  logic [62:0] numx_w, numy_w;

  assign numx_w = speed_limit_q * s5_ux_q;
  assign numy_w = speed_limit_q * s5_uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    s6_sqx_q  <= s5_ux_q * s5_ux_q;
    s6_sqy_q  <= s5_uy_q * s5_uy_q;
    s6_numx_q <= numx_w[61:0];
    s6_numy_q <= numy_w[61:0];
  end

  // Stage seven: sum of squares and the speed test.
  logic           s7_vld_q;
  logic [63:0]    s7_sum_q;
  pebb_root_tag_t s7_tag_q;
  logic [63:0]    sum_w;

  assign sum_w = s6_sqx_q + s6_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_sum_q              <= sum_w;
    s7_tag_q.side.pos_x   <= s6_side_q.pos_x;
    s7_tag_q.side.pos_y   <= s6_side_q.pos_y;
    s7_tag_q.side.vel_x   <= s6_side_q.vel_x;
    s7_tag_q.side.vel_y   <= s6_side_q.vel_y;
    s7_tag_q.side.capped  <= (sum_w > {2'b00, lim_sq_q});
    s7_tag_q.num_x        <= s6_numx_q;
    s7_tag_q.num_y        <= s6_numy_q;
  end

  // Speed magnitude.
  logic           sq_vld;
  logic [31:0]    sq_root;
  pebb_root_tag_t sq_tag;

  pebb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .rad_i   (s7_sum_q),
    .tag_i   (s7_tag_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // Rescaled velocity magnitudes.
  logic        dv_vld;
  logic [31:0] dv_qx, dv_qy;
  pebb_side_t  dv_side;

  pebb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .num_x_i (sq_tag.num_x),
    .num_y_i (sq_tag.num_y),
    .den_i   (sq_root),
    .side_i  (sq_tag.side),
    .valid_o (dv_vld),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .side_o  (dv_side)
  );

  // Output register: restore signs where the velocity was rescaled.
  logic      out_vld_q;
  pebb_out_t out_q;
  pebb_out_t out_d;

  always_comb begin
    out_d.next_x       = dv_side.pos_x;
    out_d.next_y       = dv_side.pos_y;
    out_d.speed_capped = dv_side.capped;
    if (dv_side.capped) begin
      out_d.next_vx = dv_side.vel_x[31] ? -$signed(dv_qx) : $signed(dv_qx);
      out_d.next_vy = dv_side.vel_y[31] ? -$signed(dv_qy) : $signed(dv_qy);
    end else begin
      out_d.next_vx = dv_side.vel_x;
      out_d.next_vy = dv_side.vel_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  // Magnitudes of the delivered velocity, for the checks below.
  logic [31:0] chk_mag_x, chk_mag_y;
  assign chk_mag_x = out_q.next_vx[31] ? 32'(-out_q.next_vx) : 32'(out_q.next_vx);
  assign chk_mag_y = out_q.next_vy[31] ? 32'(-out_q.next_vy) : 32'(out_q.next_vy);

  // Every result word stems from an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result word without a matching accepted word");

  // A rescaled velocity never exceeds the speed limit on either axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.speed_capped) |->
      (chk_mag_x <= {1'b0, speed_limit_q}) && (chk_mag_y <= {1'b0, speed_limit_q}))
    else $error("rescaled velocity above the speed limit");

endmodule

[rtl/core/pebb_motion.sv]
// Four-stage position and velocity update with one reflection per axis.
module pebb_motion import pebb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pebb_in_t          item_i,
  input  logic [30:0]       half_extent_i,
  input  logic [16:0]       time_step_i,
  output logic              valid_o,
  output pebb_side_t        side_o
);

  logic signed [17:0] dt_s;
  logic signed [33:0] r_s;
  assign dt_s = {1'b0, time_step_i};
  assign r_s  = {3'b000, half_extent_i};

  // Stage one: first velocity and acceleration products.
  logic               s1_vld_q;
  logic signed [31:0] s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;
  logic signed [49:0] s1_pvx_q, s1_pvy_q, s1_pax_q, s1_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q  <= item_i.pos_x;
    s1_py_q  <= item_i.pos_y;
    s1_vx_q  <= item_i.vel_x;
    s1_vy_q  <= item_i.vel_y;
    s1_pvx_q <= item_i.vel_x * dt_s;
    s1_pvy_q <= item_i.vel_y * dt_s;
    s1_pax_q <= item_i.acc_x * dt_s;
    s1_pay_q <= item_i.acc_y * dt_s;
  end

  // Stage two: advance the position, test against the box, pick the velocity.
  logic signed [31:0] px_a_d, py_a_d, vb_x_d, vb_y_d;
  logic               out_x_d, out_y_d;
  logic signed [33:0] px_w, py_w;

  always_comb begin
    px_a_d  = sat32(34'(s1_px_q) + rnd_dt(s1_pvx_q));
    py_a_d  = sat32(34'(s1_py_q) + rnd_dt(s1_pvy_q));
    px_w    = 34'(px_a_d);
    py_w    = 34'(py_a_d);
    out_x_d = (px_w > r_s) || (px_w < -r_s);
    out_y_d = (py_w > r_s) || (py_w < -r_s);
    vb_x_d  = s1_vx_q;
    vb_y_d  = s1_vy_q;
    if (out_x_d) begin
      vb_x_d = (s1_vx_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -s1_vx_q;
    end
    if (out_y_d) begin
      vb_y_d = (s1_vy_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -s1_vy_q;
    end
  end

  logic               s2_vld_q, s2_out_x_q, s2_out_y_q;
  logic signed [31:0] s2_px_q, s2_py_q, s2_vx_q, s2_vy_q;
  logic signed [49:0] s2_pax_q, s2_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_px_q    <= px_a_d;
    s2_py_q    <= py_a_d;
    s2_out_x_q <= out_x_d;
    s2_out_y_q <= out_y_d;
    s2_vx_q    <= vb_x_d;
    s2_vy_q    <= vb_y_d;
    s2_pax_q   <= s1_pax_q;
    s2_pay_q   <= s1_pay_q;
  end

  // Stage three: products of the reflected velocity.
  logic               s3_vld_q, s3_out_x_q, s3_out_y_q;
  logic signed [31:0] s3_px_q, s3_py_q, s3_vx_q, s3_vy_q;
  logic signed [49:0] s3_pbx_q, s3_pby_q, s3_pax_q, s3_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_px_q    <= s2_px_q;
    s3_py_q    <= s2_py_q;
    s3_out_x_q <= s2_out_x_q;
    s3_out_y_q <= s2_out_y_q;
    s3_vx_q    <= s2_vx_q;
    s3_vy_q    <= s2_vy_q;
    s3_pbx_q   <= s2_vx_q * dt_s;
    s3_pby_q   <= s2_vy_q * dt_s;
    s3_pax_q   <= s2_pax_q;
    s3_pay_q   <= s2_pay_q;
  end

  // Stage four: second advance after a reflection, then add acceleration.
  logic               s4_vld_q;
  pebb_side_t         s4_side_q;
  pebb_side_t         side_d;

  always_comb begin
    side_d.pos_x  = s3_out_x_q ? sat32(34'(s3_px_q) + rnd_dt(s3_pbx_q)) : s3_px_q;
    side_d.pos_y  = s3_out_y_q ? sat32(34'(s3_py_q) + rnd_dt(s3_pby_q)) : s3_py_q;
    side_d.vel_x  = sat32(34'(s3_vx_q) + rnd_dt(s3_pax_q));
    side_d.vel_y  = sat32(34'(s3_vy_q) + rnd_dt(s3_pay_q));
    side_d.capped = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= side_d;
  end

  assign valid_o = s4_vld_q;
  assign side_o  = s4_side_q;

endmodule

[rtl/core/pebb_sqrt.sv]
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module pebb_sqrt import pebb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [63:0]    rad_i,
  input  pebb_root_tag_t tag_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output pebb_root_tag_t tag_o
);

  logic           vld_q  [SQRT_STAGES];
  logic [33:0]    rem_q  [SQRT_STAGES];
  logic [31:0]    root_q [SQRT_STAGES];
  logic [63:0]    rad_q  [SQRT_STAGES];
  pebb_root_tag_t tag_q  [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic           vld_in;
    logic [33:0]    rem_in;
    logic [31:0]    root_in;
    logic [63:0]    rad_in;
    pebb_root_tag_t tag_in;
    logic [35:0]    rem_sh, trial;
    logic [33:0]    rem_d;
    logic [31:0]    root_d;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign tag_in  = tag_q[i-1];
    end

    // Bring down the next pair of bits and try the trial subtrahend.
    always_comb begin
      rem_sh = {rem_in, rad_in[63-2*i -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = 34'(rem_sh - trial);
        root_d = {root_in[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh[33:0];
        root_d = {root_in[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
      rad_q[i]  <= rad_in;
      tag_q[i]  <= tag_in;
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];
  assign tag_o   = tag_q[SQRT_STAGES-1];

endmodule

[rtl/core/pebb_div.sv]
// Pipelined restoring divider for both velocity lanes, one quotient bit per stage.
module pebb_div import pebb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [61:0] num_x_i,
  input  logic [61:0] num_y_i,
  input  logic [31:0] den_i,
  input  pebb_side_t  side_i,
  output logic        valid_o,
  output logic [31:0] quo_x_o,
  output logic [31:0] quo_y_o,
  output pebb_side_t  side_o
);

  logic        vld_q   [DIV_STAGES];
  logic [31:0] rem_x_q [DIV_STAGES];
  logic [31:0] rem_y_q [DIV_STAGES];
  logic [31:0] quo_x_q [DIV_STAGES];
  logic [31:0] quo_y_q [DIV_STAGES];
  logic [61:0] num_x_q [DIV_STAGES];
  logic [61:0] num_y_q [DIV_STAGES];
  logic [31:0] den_q   [DIV_STAGES];
  pebb_side_t  side_q  [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic        vld_in;
    logic [31:0] rem_x_in, rem_y_in, quo_x_in, quo_y_in, den_in;
    logic [61:0] num_x_in, num_y_in;
    pebb_side_t  side_in;
    logic [32:0] sh_x, sh_y;
    logic [31:0] rem_x_d, rem_y_d;
    logic        bit_x, bit_y;

    if (i == 0) begin : g_first
      assign vld_in   = valid_i;
      assign rem_x_in = {2'b00, num_x_i[61:32]};
      assign rem_y_in = {2'b00, num_y_i[61:32]};
      assign quo_x_in = '0;
      assign quo_y_in = '0;
      assign num_x_in = num_x_i;
      assign num_y_in = num_y_i;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign vld_in   = vld_q[i-1];
      assign rem_x_in = rem_x_q[i-1];
      assign rem_y_in = rem_y_q[i-1];
      assign quo_x_in = quo_x_q[i-1];
      assign quo_y_in = quo_y_q[i-1];
      assign num_x_in = num_x_q[i-1];
      assign num_y_in = num_y_q[i-1];
      assign den_in   = den_q[i-1];
      assign side_in  = side_q[i-1];
    end

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb begin
      sh_x  = {rem_x_in, num_x_in[31-i]};
      sh_y  = {rem_y_in, num_y_in[31-i]};
      bit_x = (sh_x >= {1'b0, den_in});
      bit_y = (sh_y >= {1'b0, den_in});
      rem_x_d = bit_x ? 32'(sh_x - {1'b0, den_in}) : sh_x[31:0];
      rem_y_d = bit_y ? 32'(sh_y - {1'b0, den_in}) : sh_y[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_x_q[i] <= rem_x_d;
      rem_y_q[i] <= rem_y_d;
      quo_x_q[i] <= {quo_x_in[30:0], bit_x};
      quo_y_q[i] <= {quo_y_in[30:0], bit_y};
      num_x_q[i] <= num_x_in;
      num_y_q[i] <= num_y_in;
      den_q[i]   <= den_in;
      side_q[i]  <= side_in;
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quo_x_o = quo_x_q[DIV_STAGES-1];
  assign quo_y_o = quo_y_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule
